FILE: design/hcib_pkg.sv
// ----------------------------------------------------------------------------
// hcib_pkg: shared types and constants
// Command codes, parser and reply phases, and the controller/datapath link.
// ----------------------------------------------------------------------------
package hcib_pkg;

	localparam logic [1:0] REQ_CHAR = 2'd0;
	localparam logic [1:0] REQ_DONE = 2'd1;
	localparam logic [1:0] REQ_DATA = 2'd2;
	localparam logic [1:0] REQ_PULL = 2'd3;

	localparam logic [1:0] KIND_CHAR  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_WBYTE = 2'd2;

	localparam logic [7:0] CH_CR   = 8'h0d;
	localparam logic [7:0] CH_LS   = 8'h73;
	localparam logic [7:0] CH_LR   = 8'h72;
	localparam logic [7:0] CH_US   = 8'h53;
	localparam logic [7:0] CH_UR   = 8'h52;
	localparam logic [7:0] CH_BANG = 8'h21;

	typedef enum logic [2:0] {
		P_CMD, P_AHI, P_ALO, P_DATA, P_DLO
	} parse_t;

	typedef enum logic [2:0] {
		R_NONE, R_HEAD, R_HI, R_LO, R_CR, R_BANG
	} reply_t;

	typedef enum logic [1:0] {
		W_IDLE, W_WRITE, W_READ
	} wait_t;

	typedef enum logic [1:0] {
		C_IDLE, C_START, C_WBYTE, C_REPLY
	} ctl_t;

	// controller -> datapath
	typedef struct packed {
		logic take;      // item accepted
		logic start_emit;// emit transfer start
		logic wbyte_emit;// emit one write byte
		logic reply_emit;// emit one reply char
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic eol_write;  // line ended with a write
		logic eol_read;   // line ended with a valid read
		logic wr_more;    // more write bytes after this one
		logic has_reply;  // pull yields a character
	} dp_stat_t;

	function automatic logic [4:0] hex_value(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
		if (c >= 8'h61 && c <= 8'h66) return {1'b0, c[3:0] + 4'd9};
		if (c >= 8'h41 && c <= 8'h46) return {1'b0, c[3:0] + 4'd9};
		return 5'h10;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h57 + {4'd0, v});
	endfunction

endpackage

FILE: design/hcib_if.sv
// ----------------------------------------------------------------------------
// hcib_if: valid/ready channel
// Carries one item per handshake; payload type set by parameter.
// ----------------------------------------------------------------------------
interface hcib_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/hcib_ctrl.sv
// ----------------------------------------------------------------------------
// hcib_ctrl: sequencing state machine
// Accepts items, then walks the result run (start, write bytes, reply char).
// ----------------------------------------------------------------------------
module hcib_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          in_req,
	output logic                out_valid,
	input  logic                out_ready,
	input  hcib_pkg::dp_stat_t  stat,
	output hcib_pkg::dp_cmd_t   cmd
);
	hcib_pkg::ctl_t state_q, state_d;
	logic fire_out;

	assign fire_out = out_valid & out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			hcib_pkg::C_IDLE: begin
				if (in_valid) begin
					if (stat.eol_write || stat.eol_read)
						state_d = hcib_pkg::C_START;
					else if (in_req == hcib_pkg::REQ_PULL && stat.has_reply)
						state_d = hcib_pkg::C_REPLY;
				end
			end
			hcib_pkg::C_START: begin
				if (fire_out)
					state_d = stat.wr_more ? hcib_pkg::C_WBYTE : hcib_pkg::C_IDLE;
			end
			hcib_pkg::C_WBYTE: begin
				if (fire_out && !stat.wr_more) state_d = hcib_pkg::C_IDLE;
			end
			hcib_pkg::C_REPLY: begin
				if (fire_out) state_d = hcib_pkg::C_IDLE;
			end
			default: state_d = hcib_pkg::C_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		out_valid      = 1'b0;
		cmd            = '0;
		case (state_q)
			hcib_pkg::C_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			hcib_pkg::C_START: begin
				out_valid      = 1'b1;
				cmd.start_emit = fire_out;
			end
			hcib_pkg::C_WBYTE: begin
				out_valid      = 1'b1;
				cmd.wbyte_emit = fire_out;
			end
			hcib_pkg::C_REPLY: begin
				out_valid      = 1'b1;
				cmd.reply_emit = fire_out;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= hcib_pkg::C_IDLE;
		else state_q <= state_d;
	end
endmodule

FILE: design/hcib_dp.sv
// ----------------------------------------------------------------------------
// hcib_dp: parser, byte store and reply datapath
// Holds the parse state, the byte buffer and the reply sequencer registers.
// ----------------------------------------------------------------------------
module hcib_dp #(
	parameter int BUF_DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hcib_pkg::dp_cmd_t   cmd,
	output hcib_pkg::dp_stat_t  stat,
	input  logic [1:0]          req_type,
	input  logic [7:0]          host_char,
	input  logic [7:0]          twi_result,
	input  logic [7:0]          twi_data_in,
	output logic [1:0]          res_kind,
	output logic [7:0]          reply_char,
	output logic                twi_is_read,
	output logic [7:0]          slave_address,
	output logic [5:0]          transfer_length,
	output logic [7:0]          write_byte,
	output logic                last
);
	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam logic [5:0] DEPTH6 = 6'(BUF_DEPTH);

	hcib_pkg::parse_t parse_q;
	hcib_pkg::reply_t reply_q, reply_held_q;
	hcib_pkg::wait_t  wait_q;
	logic       cmd_read_q;
	logic [7:0] slave_q;
	logic [3:0] nib_q;
	logic [5:0] fill_q, rptr_q, rexp_q, len_q;
	logic [7:0] byte0_q;    // first data byte of the line (read length)
	logic [7:0] mem [BUF_DEPTH];
	logic [7:0] rd_q;       // registered store read
	logic       start_rd_q;

	logic [4:0] hv;
	logic       is_hex, is_char;
	logic       wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [7:0] wr_data;
	logic [5:0] rlen;
	logic [7:0] nxt_char;
	hcib_pkg::reply_t nxt_phase;
	logic       ptr_inc;

	assign hv      = hcib_pkg::hex_value(host_char);
	assign is_hex  = ~hv[4];
	assign is_char = cmd.take && req_type == hcib_pkg::REQ_CHAR && wait_q == hcib_pkg::W_IDLE;

	assign stat.eol_write = is_char && parse_q == hcib_pkg::P_DATA && host_char == hcib_pkg::CH_CR
		&& !cmd_read_q;
	assign stat.eol_read  = is_char && parse_q == hcib_pkg::P_DATA && host_char == hcib_pkg::CH_CR
		&& cmd_read_q && fill_q == 6'd1;
	assign stat.has_reply = reply_q != hcib_pkg::R_NONE;

	// read length from first byte, saturated
	assign rlen = (byte0_q > {2'd0, DEPTH6}) ? DEPTH6 : byte0_q[5:0];

	// reply character and next phase for a pull
	always_comb begin
		nxt_char  = hcib_pkg::CH_CR;
		nxt_phase = hcib_pkg::R_NONE;
		ptr_inc   = 1'b0;
		case (reply_q)
			hcib_pkg::R_HEAD: begin
				nxt_char  = cmd_read_q ? hcib_pkg::CH_UR : hcib_pkg::CH_US;
				nxt_phase = (rptr_q < fill_q) ? hcib_pkg::R_HI : hcib_pkg::R_CR;
			end
			hcib_pkg::R_HI: begin
				nxt_char  = hcib_pkg::hex_char(rd_q[7:4]);
				nxt_phase = hcib_pkg::R_LO;
			end
			hcib_pkg::R_LO: begin
				nxt_char  = hcib_pkg::hex_char(rd_q[3:0]);
				ptr_inc   = 1'b1;
				nxt_phase = (rptr_q + 6'd1 < fill_q) ? hcib_pkg::R_HI : hcib_pkg::R_CR;
			end
			hcib_pkg::R_CR: nxt_phase = hcib_pkg::R_NONE;
			hcib_pkg::R_BANG: begin
				nxt_char  = hcib_pkg::CH_BANG;
				nxt_phase = hcib_pkg::R_CR;
			end
			default: ;
		endcase
	end

	// store write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = fill_q[AW-1:0];
		wr_data = {nib_q, hv[3:0]};
		if (is_char && parse_q == hcib_pkg::P_DLO && is_hex && fill_q < DEPTH6) wr_en = 1'b1;
		if (cmd.take && req_type == hcib_pkg::REQ_DONE && wait_q == hcib_pkg::W_WRITE) begin
			wr_en = 1'b1; wr_addr = '0; wr_data = twi_result;
		end
		if (cmd.take && req_type == hcib_pkg::REQ_DATA && wait_q == hcib_pkg::W_READ
			&& fill_q < rexp_q && fill_q < DEPTH6) begin
			wr_en = 1'b1; wr_data = twi_data_in;
		end
	end

	// read address: current reply / write byte pointer
	always_comb begin
		rd_addr = rptr_q[AW-1:0];
		if (is_char || (cmd.take && req_type == hcib_pkg::REQ_DONE)) rd_addr = '0;
		else if (cmd.start_emit) rd_addr = '0;
		else if (cmd.wbyte_emit || (cmd.reply_emit && ptr_inc)) rd_addr = AW'(rptr_q + 6'd1);
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_addr < AW'(BUF_DEPTH - 1) || rd_addr == AW'(BUF_DEPTH - 1))
			rd_q <= (wr_en && wr_addr == rd_addr) ? wr_data : mem[rd_addr];
		else
			rd_q <= '0;
	end

	assign stat.wr_more = cmd_read_q ? 1'b0
		: (reply_held_q == hcib_pkg::R_NONE && start_rd_q) ? (fill_q != 6'd0)
		: (rptr_q + 6'd1 < fill_q);

	// output payload
	always_comb begin
		res_kind        = hcib_pkg::KIND_CHAR;
		reply_char      = '0;
		twi_is_read     = 1'b0;
		slave_address   = '0;
		transfer_length = '0;
		write_byte      = '0;
		last            = 1'b1;
		if (start_rd_q) begin
			res_kind        = hcib_pkg::KIND_START;
			twi_is_read     = cmd_read_q;
			slave_address   = slave_q;
			transfer_length = len_q;
			last            = cmd_read_q || fill_q == 6'd0;
		end else if (wait_q == hcib_pkg::W_WRITE && reply_held_q == hcib_pkg::R_NONE
			&& !cmd_read_q) begin
			res_kind   = hcib_pkg::KIND_WBYTE;
			write_byte = rd_q;
			last       = !(rptr_q + 6'd1 < fill_q);
		end else begin
			reply_char = nxt_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_q      <= hcib_pkg::P_CMD;
			reply_q      <= hcib_pkg::R_NONE;
			reply_held_q <= hcib_pkg::R_NONE;
			wait_q       <= hcib_pkg::W_IDLE;
			cmd_read_q   <= 1'b0;
			slave_q      <= '0;
			nib_q        <= '0;
			fill_q       <= '0;
			rptr_q       <= '0;
			rexp_q       <= '0;
			len_q        <= '0;
			byte0_q      <= '0;
			start_rd_q   <= 1'b0;
		end else begin
			reply_held_q <= reply_q;
			if (is_char) begin
				reply_q <= hcib_pkg::R_NONE;
				case (parse_q)
					hcib_pkg::P_CMD: begin
						if (host_char == hcib_pkg::CH_LS || host_char == hcib_pkg::CH_LR) begin
							cmd_read_q <= host_char == hcib_pkg::CH_LR;
							fill_q     <= '0;
							parse_q    <= hcib_pkg::P_AHI;
						end else begin
							fill_q <= '0; rptr_q <= '0; reply_q <= hcib_pkg::R_BANG;
						end
					end
					hcib_pkg::P_AHI: begin
						if (is_hex) begin
							nib_q <= hv[3:0]; parse_q <= hcib_pkg::P_ALO;
						end else begin
							fill_q <= '0; rptr_q <= '0; reply_q <= hcib_pkg::R_BANG;
							parse_q <= hcib_pkg::P_CMD;
						end
					end
					hcib_pkg::P_ALO: begin
						if (is_hex) begin
							slave_q <= {nib_q, hv[3:0]}; parse_q <= hcib_pkg::P_DATA;
						end else begin
							fill_q <= '0; rptr_q <= '0; reply_q <= hcib_pkg::R_BANG;
							parse_q <= hcib_pkg::P_CMD;
						end
					end
					hcib_pkg::P_DATA: begin
						if (host_char == hcib_pkg::CH_CR) begin
							parse_q <= hcib_pkg::P_CMD;
							if (!cmd_read_q) begin
								start_rd_q <= 1'b1;
								len_q      <= fill_q;
								rptr_q     <= '1; // walks from 0 after start
								wait_q     <= hcib_pkg::W_WRITE;
							end else if (fill_q == 6'd1) begin
								start_rd_q <= 1'b1;
								len_q      <= rlen;
								rexp_q     <= rlen;
								fill_q     <= '0;
								wait_q     <= hcib_pkg::W_READ;
							end else begin
								fill_q <= '0; rptr_q <= '0; reply_q <= hcib_pkg::R_BANG;
							end
						end else if (fill_q < DEPTH6 && is_hex) begin
							nib_q <= hv[3:0]; parse_q <= hcib_pkg::P_DLO;
						end else begin
							fill_q <= '0; rptr_q <= '0; reply_q <= hcib_pkg::R_BANG;
							parse_q <= hcib_pkg::P_CMD;
						end
					end
					hcib_pkg::P_DLO: begin
						if (is_hex && fill_q < DEPTH6) begin
							if (fill_q == 6'd0) byte0_q <= {nib_q, hv[3:0]};
							fill_q <= fill_q + 6'd1; parse_q <= hcib_pkg::P_DATA;
						end else begin
							fill_q <= '0; rptr_q <= '0; reply_q <= hcib_pkg::R_BANG;
							parse_q <= hcib_pkg::P_CMD;
						end
					end
					default: parse_q <= hcib_pkg::P_CMD;
				endcase
			end
			// write bytes are walked with rptr_q on the byte being shown
			if (cmd.start_emit) begin
				start_rd_q <= 1'b0;
				rptr_q     <= '0;
			end
			if (cmd.wbyte_emit) rptr_q <= rptr_q + 6'd1;
			if (cmd.take && req_type == hcib_pkg::REQ_DONE && wait_q != hcib_pkg::W_IDLE) begin
				if (wait_q == hcib_pkg::W_WRITE) fill_q <= 6'd1;
				else fill_q <= ({2'd0, rexp_q} < twi_result) ? rexp_q : twi_result[5:0];
				rptr_q  <= '0;
				reply_q <= hcib_pkg::R_HEAD;
				wait_q  <= hcib_pkg::W_IDLE;
			end
			if (wr_en && req_type == hcib_pkg::REQ_DATA) fill_q <= fill_q + 6'd1;
			if (cmd.reply_emit) begin
				reply_q <= nxt_phase;
				if (ptr_inc) rptr_q <= rptr_q + 6'd1;
			end
		end
	end
endmodule

FILE: design/hex_command_i2c_bridge.sv
// ----------------------------------------------------------------------------
// hex_command_i2c_bridge: ASCII hex command line to I2C bridge
// Parses host command lines, issues I2C transfers and serves the reply.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | req_type, host_char, twi_result, twi_data_in
//  res     | out | res_kind, reply_char, twi_is_read, slave_address,
//          |     | transfer_length, write_byte, last
//
// An item with no result is simply taken; an item with results is followed
// by one result per handshake (end of a write line: start plus each byte).
// The next item is taken once the last result of the run is delivered.
// Output stalls hold the run in place. Reset clears all control state;
// the byte store is not cleared.
module hex_command_i2c_bridge #(
	parameter int BUF_DEPTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	hcib_if.sink   req,
	hcib_if.source res
);
	hcib_pkg::dp_cmd_t  cmd;
	hcib_pkg::dp_stat_t stat;

	hcib_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready), .in_req(req.data.req_type),
		.out_valid(res.valid), .out_ready(res.ready),
		.stat(stat), .cmd(cmd)
	);

	hcib_dp #(.BUF_DEPTH(BUF_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.req_type(req.data.req_type), .host_char(req.data.host_char),
		.twi_result(req.data.twi_result), .twi_data_in(req.data.twi_data_in),
		.res_kind(res.data.res_kind), .reply_char(res.data.reply_char),
		.twi_is_read(res.data.twi_is_read), .slave_address(res.data.slave_address),
		.transfer_length(res.data.transfer_length), .write_byte(res.data.write_byte),
		.last(res.data.last)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !req.ready) else $error("input taken during result run");
	a_start_once: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.start_emit) |=> !cmd.start_emit) else $error("double start");
endmodule
